>>> hw/rtl/tprc_pkg.sv
package tprc_pkg;

  localparam int DIV_W     = 26;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int LIM_W     = 16;
  localparam int IDX_W     = 3;
  localparam int STEP_W    = 4;
  localparam int SHIFT_W   = 4;

  localparam logic [DIV_W-1:0]  CLK_RESET    = DIV_W'(16000000);
  localparam logic [LIM_W-1:0]  LIMIT_WIDE   = 16'hffff;
  localparam logic [LIM_W-1:0]  LIMIT_NARROW = 16'h00ff;
  localparam logic [IDX_W-1:0]  IDX_LAST     = 3'd4;

  // microprogram addresses
  localparam logic [STEP_W-1:0] ST_WAIT     = 4'd0;
  localparam logic [STEP_W-1:0] ST_ZCHK     = 4'd1;
  localparam logic [STEP_W-1:0] ST_DIV_LOAD = 4'd2;
  localparam logic [STEP_W-1:0] ST_DIV_RUN  = 4'd3;
  localparam logic [STEP_W-1:0] ST_TEST     = 4'd4;
  localparam logic [STEP_W-1:0] ST_NEXT     = 4'd5;
  localparam logic [STEP_W-1:0] ST_MISS     = 4'd6;
  localparam logic [STEP_W-1:0] ST_FOUND    = 4'd7;
  localparam logic [STEP_W-1:0] ST_ZERO     = 4'd8;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_IDX_INC,
    OP_EMIT_FOUND,
    OP_EMIT_MISS,
    OP_EMIT_ZERO
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_RATE_ZERO,
    COND_DIV_MORE,
    COND_FITS,
    COND_NOT_LAST
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic rate_zero;
    logic div_more;
    logic fits;
    logic not_last;
  } seq_stat_t;

  // prescalers 1, 8, 64, 256, 1024 as right shifts
  function automatic logic [SHIFT_W-1:0] presc_shift(input logic [IDX_W-1:0] idx);
    logic [SHIFT_W-1:0] sh;
    case (idx)
      3'd0:    sh = 4'd0;
      3'd1:    sh = 4'd3;
      3'd2:    sh = 4'd6;
      3'd3:    sh = 4'd8;
      3'd4:    sh = 4'd10;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      ST_WAIT:     w = '{OP_LATCH,      COND_NO_START,  ST_WAIT};
      ST_ZCHK:     w = '{OP_NOP,        COND_RATE_ZERO, ST_ZERO};
      ST_DIV_LOAD: w = '{OP_DIV_LOAD,   COND_NEVER,     ST_WAIT};
      ST_DIV_RUN:  w = '{OP_DIV_STEP,   COND_DIV_MORE,  ST_DIV_RUN};
      ST_TEST:     w = '{OP_NOP,        COND_FITS,      ST_FOUND};
      ST_NEXT:     w = '{OP_IDX_INC,    COND_NOT_LAST,  ST_DIV_LOAD};
      ST_MISS:     w = '{OP_EMIT_MISS,  COND_ALWAYS,    ST_WAIT};
      ST_FOUND:    w = '{OP_EMIT_FOUND, COND_ALWAYS,    ST_WAIT};
      ST_ZERO:     w = '{OP_EMIT_ZERO,  COND_ALWAYS,    ST_WAIT};
      default:     w = '{OP_NOP,        COND_ALWAYS,    ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/tprc_div.sv
module tprc_div
  import tprc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             step,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             more
);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  // restoring division, one quotient bit per cycle while step is high
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (load) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(DIV_W);
    end else if (step && cnt_r != '0) begin
      rem_nxt = ge ? DIV_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign more     = cnt_r > CNT_W'(1);

endmodule

>>> hw/rtl/tprc_seq.sv
module tprc_seq
  import tprc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output uword_t    uw,
  output logic      busy
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              take;

  assign uw = ucode(step_r);

  always_comb begin
    case (uw.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = !stat.start;
      COND_RATE_ZERO: take = stat.rate_zero;
      COND_DIV_MORE:  take = stat.div_more;
      COND_FITS:      take = stat.fits;
      COND_NOT_LAST:  take = stat.not_last;
      default:        take = 1'b1;
    endcase
    step_nxt = take ? uw.target : step_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign busy = step_r != ST_WAIT;

endmodule

>>> hw/rtl/timer_prescaler_reload_calc_top.sv
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+------------------------------
// request  | in_rate_hz, in_narrow_timer             | start, busy
// result   | out_prescaler_index, out_reload_value,  | out_strobe, one cycle
//          | out_not_found, out_zero_rate            |
// config   | cfg_wdata                               | cfg_we
//
// a zero rate goes from the wait step through ZCHK and ZERO to the registered result
// each prescaler tried runs a load and the shared 26-step restoring divider, then a test
// busy stays high until the result cycle
// synchronous reset returns the sequencer to its wait step and clk_hz_r to 16000000
// the receiver cannot stall: each result shows for exactly one cycle
module timer_prescaler_reload_calc_top
  import tprc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [25:0]      in_rate_hz,
  input  logic             in_narrow_timer,
  output logic             out_strobe,
  output logic [2:0]       out_prescaler_index,
  output logic [15:0]      out_reload_value,
  output logic             out_not_found,
  output logic             out_zero_rate,
  input  logic             cfg_we,
  input  logic [25:0]      cfg_wdata
);

  uword_t            uw;
  seq_stat_t         stat;
  logic [DIV_W-1:0]  clk_hz_r;
  logic [DIV_W-1:0]  rate_r;
  logic              narrow_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DIV_W-1:0]  quotient;
  logic              div_more;
  logic [LIM_W-1:0]  limit;
  logic [DIV_W-1:0]  dividend;
  logic              out_strobe_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [LIM_W-1:0]  out_reload_r;
  logic              out_not_found_r;
  logic              out_zero_rate_r;

  assign limit    = narrow_r ? LIMIT_NARROW : LIMIT_WIDE;
  assign dividend = clk_hz_r >> presc_shift(idx_r);

  assign stat.start     = start;
  assign stat.rate_zero = rate_r == '0;
  assign stat.div_more  = div_more;
  assign stat.fits      = quotient < {{(DIV_W-LIM_W){1'b0}}, limit};
  assign stat.not_last  = idx_r != IDX_LAST;

  tprc_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .uw   (uw),
    .busy (busy)
  );

  tprc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (uw.op == OP_DIV_LOAD),
    .step    (uw.op == OP_DIV_STEP),
    .dividend(dividend),
    .divisor (rate_r),
    .quotient(quotient),
    .more    (div_more)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r     <= CLK_RESET;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        clk_hz_r <= cfg_wdata;
      end
      out_strobe_r <= 1'b0;
      case (uw.op)
        OP_LATCH: begin
          if (start) begin
            idx_r <= '0;
          end
        end
        OP_IDX_INC: begin
          if (stat.not_last) begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        OP_EMIT_FOUND, OP_EMIT_MISS, OP_EMIT_ZERO: begin
          out_strobe_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
    // payload
    case (uw.op)
      OP_LATCH: begin
        if (start) begin
          rate_r   <= in_rate_hz;
          narrow_r <= in_narrow_timer;
        end
      end
      OP_EMIT_FOUND: begin
        out_idx_r       <= idx_r;
        out_reload_r    <= limit - quotient[LIM_W-1:0];
        out_not_found_r <= 1'b0;
        out_zero_rate_r <= 1'b0;
      end
      OP_EMIT_MISS: begin
        out_idx_r       <= '0;
        out_reload_r    <= '0;
        out_not_found_r <= 1'b1;
        out_zero_rate_r <= 1'b0;
      end
      OP_EMIT_ZERO: begin
        out_idx_r       <= '0;
        out_reload_r    <= '0;
        out_not_found_r <= 1'b0;
        out_zero_rate_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_strobe          = out_strobe_r;
  assign out_prescaler_index = out_idx_r;
  assign out_reload_value    = out_reload_r;
  assign out_not_found       = out_not_found_r;
  assign out_zero_rate       = out_zero_rate_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while a request is still in work");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_not_found && out_zero_rate))
    else $error("not_found and zero_rate both set");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_prescaler_index <= IDX_LAST)
    else $error("prescaler index out of range");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tprc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 160;
  localparam logic [25:0] RATE_MASK = 26'h3ffffff;
  // prescaler divisors, index 0 in the low slice
  localparam logic [4:0][10:0] PRESC_DIV = {11'd1024, 11'd256, 11'd64, 11'd8, 11'd1};

  typedef struct packed {
    logic [IDX_W-1:0] prescaler_index;
    logic [LIM_W-1:0] reload_value;
    logic             not_found;
    logic             zero_rate;
  } reload_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [25:0]       in_rate_hz;
  logic              in_narrow_timer;
  logic              out_strobe;
  logic [IDX_W-1:0]  out_prescaler_index;
  logic [LIM_W-1:0]  out_reload_value;
  logic              out_not_found;
  logic              out_zero_rate;
  logic              cfg_we;
  logic [25:0]       cfg_wdata;

  reload_result_t pending_reloads[$];
  logic [25:0]    cpu_clock_hz;
  int             mismatches;
  int             stall_cycles;
  int             idle_pct;

  timer_prescaler_reload_calc_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_rate_hz          (in_rate_hz),
    .in_narrow_timer     (in_narrow_timer),
    .out_strobe          (out_strobe),
    .out_prescaler_index (out_prescaler_index),
    .out_reload_value    (out_reload_value),
    .out_not_found       (out_not_found),
    .out_zero_rate       (out_zero_rate),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic reload_result_t calc_reload(input logic [25:0] rate, input logic narrow);
    reload_result_t r;
    logic [31:0]    limit;
    logic [31:0]    count;
    int unsigned    k;
    r = '0;
    limit = narrow ? 32'(LIMIT_NARROW) : 32'(LIMIT_WIDE);
    if (rate == 0) begin
      r.zero_rate = 1'b1;
    end else begin
      r.not_found = 1'b1;
      for (k = 0; k < 5 && r.not_found; k++) begin
        count = (32'(cpu_clock_hz) / 32'(PRESC_DIV[k])) / 32'(rate);
        if (count < limit) begin
          r.prescaler_index = IDX_W'(k);
          r.reload_value = LIM_W'(limit - count);
          r.not_found = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // rates spread over magnitudes, with extra weight near the fit boundaries
  function automatic logic [25:0] pick_rate();
    logic [31:0] edge_rate;
    logic [31:0] lim;
    int          k;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 26'($urandom);
      2, 3: return 26'($urandom_range(1, 300));
      4, 5: begin
        k = $urandom_range(0, 4);
        lim = $urandom_range(0, 1) ? 32'd255 : 32'd65535;
        edge_rate = 32'(cpu_clock_hz) / 32'(PRESC_DIV[k]) / lim;
        edge_rate = edge_rate + 32'($urandom_range(0, 4)) - 32'd2;
        return 26'(edge_rate);
      end
      default: return 26'($urandom) & (RATE_MASK >> $urandom_range(0, 26));
    endcase
  endfunction

  task automatic send_request(input logic [25:0] rate, input logic narrow);
    in_rate_hz <= rate;
    in_narrow_timer <= narrow;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_reloads.push_back(calc_reload(rate, narrow));
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    while (pending_reloads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cpu_clock(input logic [25:0] value);
    drain_requests();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cpu_clock_hz = value;
    @(posedge clk);
  endtask

  task automatic random_requests(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_request(pick_rate(), 1'($urandom));
      if ($urandom_range(0, 199) == 0) drain_requests();
      else maybe_idle();
    end
  endtask

  // reset clock: zero rate, top rate, exact-limit count, no fit
  task automatic test_directed();
    idle_pct = 30;
    send_request(26'd0, 1'b0);
    send_request(26'd0, 1'b1);
    send_request(26'd1, 1'b0);
    send_request(26'd1, 1'b1);
    send_request(RATE_MASK, 1'b0);
    send_request(RATE_MASK, 1'b1);
    send_request(26'd50000000, 1'b1);
    send_request(26'd62745, 1'b1);
    send_request(26'd245, 1'b0);
    send_request(26'd244, 1'b0);
    maybe_idle();
    send_request(26'd1000, 1'b1);
    send_request(26'd61, 1'b1);
  endtask

  // clock register at its extremes, including zero and all ones
  task automatic test_clock_extremes();
    logic [25:0] clocks[4];
    int          c;
    clocks = '{26'd1, 26'd50000000, 26'd0, RATE_MASK};
    for (c = 0; c < 4; c++) begin
      write_cpu_clock(clocks[c]);
      send_request(26'd1, 1'b0);
      send_request(26'd1, 1'b1);
      send_request(26'd0, 1'b0);
    end
  endtask

  task automatic test_random_clocks();
    int p;
    idle_pct = 25;
    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: write_cpu_clock(26'($urandom_range(1, 50000000)));
        1: write_cpu_clock(26'($urandom));
        2: write_cpu_clock(26'($urandom_range(1, 2000)));
        default: write_cpu_clock(26'd16000000);
      endcase
      random_requests(150);
    end
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    write_cpu_clock(26'($urandom_range(1, 50000000)));
    random_requests(300);
  endtask

  // result checker and stall watchdog
  always @(posedge clk) begin
    reload_result_t exp_r;
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (out_strobe || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (out_strobe) begin
        if (pending_reloads.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: index %0d reload %h not_found %b zero_rate %b",
                     out_prescaler_index, out_reload_value, out_not_found, out_zero_rate);
          mismatches++;
        end else begin
          exp_r = pending_reloads.pop_front();
          if (exp_r.prescaler_index !== out_prescaler_index ||
              exp_r.reload_value !== out_reload_value ||
              exp_r.not_found !== out_not_found ||
              exp_r.zero_rate !== out_zero_rate) begin
            if (mismatches < 10)
              $display("mismatch: exp idx %0d reload %h nf %b zr %b, got %0d %h %b %b",
                       exp_r.prescaler_index, exp_r.reload_value, exp_r.not_found,
                       exp_r.zero_rate, out_prescaler_index, out_reload_value,
                       out_not_found, out_zero_rate);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    idle_pct = 0;
    cpu_clock_hz = 26'd16000000;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_rate_hz <= '0;
    in_narrow_timer <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_clock_extremes();
    test_random_clocks();
    test_back_to_back();

    start <= 1'b0;
    while (pending_reloads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reloads.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tprc_pkg.sv
hw/rtl/tprc_div.sv
hw/rtl/tprc_seq.sv
hw/rtl/timer_prescaler_reload_calc_top.sv
verif/testbench.sv
